### sv/i2c_register_read_sequencer_macros.svh
// Assertion macros used by the register read sequencer checker.
`ifndef I2C_REGISTER_READ_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_READ_SEQUENCER_MACROS_SVH

// Clocked check, switched off while reset is held.
`define I2CRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds across reset.
`define I2CRR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### sv/i2crr_pkg.sv
// Types, codes and beat layouts of the I2C register read sequencer.
`default_nettype none
package i2crr_pkg;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 32;

    // Sequence phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ADDR_W  = 3'd1;
    localparam logic [2:0] PH_REG     = 3'd2;
    localparam logic [2:0] PH_RESTART = 3'd3;
    localparam logic [2:0] PH_LOW     = 3'd4;
    localparam logic [2:0] PH_HIGH    = 3'd5;
    localparam logic [2:0] PH_STOP    = 3'd6;

    // Master engine state codes
    localparam logic [2:0] ST_RX_READY = 3'd1;
    localparam logic [2:0] ST_TX_READY = 3'd2;
    localparam logic [2:0] ST_NACK_ADR = 3'd3;
    localparam logic [2:0] ST_NACK_DAT = 3'd4;

    // Engine commands
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_CONTINUE = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;
    localparam logic [1:0] CMD_STOP     = 2'd3;

    // Request kinds carried in tuser
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_EVENT   = 1'b1;

    typedef struct packed {
        logic [2:0]  phase;
        logic [6:0]  target_address;
        logic [7:0]  target_register;
        logic [15:0] data_word;
        logic        ready_flag;
        logic        irq_enabled;
    } seq_state_t;

    typedef struct packed {
        logic        mode;
        logic [6:0]  slave_address;
        logic [7:0]  register_address;
        logic        pending;
        logic [2:0]  bus_state;
        logic [7:0]  received_byte;
    } seq_in_t;

    typedef struct packed {
        logic        write_valid;
        logic [7:0]  write_byte;
        logic [1:0]  command;
    } seq_action_t;

endpackage
`default_nettype wire

### sv/i2crr_step.sv
// Next-state and action logic for one request or engine event.
`default_nettype none
module i2crr_step (
    input  wire i2crr_pkg::seq_state_t  state_cur,
    input  wire i2crr_pkg::seq_in_t     beat,
    output i2crr_pkg::seq_state_t       state_nxt,
    output i2crr_pkg::seq_action_t      action
);
    import i2crr_pkg::*;

    logic is_nack;

    assign is_nack = (beat.bus_state == ST_NACK_ADR) || (beat.bus_state == ST_NACK_DAT);

    always_comb begin
        state_nxt          = state_cur;
        action.write_valid = 1'b0;
        action.write_byte  = 8'h00;
        action.command     = CMD_NONE;

        if (beat.mode == MODE_REQUEST) begin
            // a request while busy is dropped
            if (state_cur.phase == PH_IDLE) begin
                state_nxt.target_address  = beat.slave_address;
                state_nxt.target_register = beat.register_address;
                state_nxt.ready_flag      = 1'b0;
                state_nxt.irq_enabled     = 1'b1;
                state_nxt.phase           = PH_ADDR_W;
                action.write_valid        = 1'b1;
                action.write_byte         = {beat.slave_address, 1'b0};
                action.command            = CMD_START;
            end
        end else if (beat.pending) begin
            if (is_nack) begin
                state_nxt.irq_enabled = 1'b0;
                state_nxt.phase       = PH_IDLE;
                action.command        = CMD_STOP;
            end else begin
                unique case (state_cur.phase)
                    PH_ADDR_W: begin
                        if (beat.bus_state == ST_TX_READY) begin
                            action.write_valid = 1'b1;
                            action.write_byte  = state_cur.target_register;
                            action.command     = CMD_CONTINUE;
                            state_nxt.phase    = PH_REG;
                        end
                    end
                    PH_REG: begin
                        if (beat.bus_state == ST_TX_READY) begin
                            action.write_valid = 1'b1;
                            action.write_byte  = {state_cur.target_address, 1'b1};
                            action.command     = CMD_START;
                            state_nxt.phase    = PH_RESTART;
                        end
                    end
                    PH_RESTART: begin
                        if (beat.bus_state == ST_RX_READY) begin
                            state_nxt.data_word = {8'h00, beat.received_byte};
                            action.command      = CMD_CONTINUE;
                            state_nxt.phase     = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        if (beat.bus_state == ST_RX_READY) begin
                            state_nxt.data_word = {beat.received_byte,
                                                   state_cur.data_word[7:0]};
                            action.command      = CMD_CONTINUE;
                            state_nxt.phase     = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        action.command  = CMD_STOP;
                        state_nxt.phase = PH_STOP;
                    end
                    PH_STOP: begin
                        state_nxt.irq_enabled = 1'b0;
                        state_nxt.ready_flag  = 1'b1;
                        state_nxt.phase       = PH_IDLE;
                    end
                    default: begin
                        // idle and the unused code: nothing to do
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### sv/i2c_register_read_sequencer.sv
// Top level of the I2C register read sequencer.
// Each beat on the s_ side is either a read request (tuser low) or an event from the I2C
// master engine (tuser high); each accepted beat yields exactly one result beat on the m_
// side in the cycle after, with the byte to write, the command to issue and the status after
// the step. The sequence state is updated in the cycle a beat is accepted, so a beat can
// be taken every cycle unless m_ stalls; the output register is the only storage between
// the two sides and s_tready stays high while the result register is empty or being drained.
`default_nettype none
module i2c_register_read_sequencer (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // [6:0] slave_address, [14:7] register_address, [15] pending, [18:16] bus_state,
    // [26:19] received_byte, [31:27] zero
    input  wire [i2crr_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] mode
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [0] write_valid, [8:1] write_byte, [10:9] command, [11] irq_enable,
    // [27:12] read_value, [28] data_ready, [29] busy_res, [31:30] zero
    output logic [i2crr_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2crr_pkg::*;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    seq_in_t              beat;
    seq_action_t          action;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 s_accept;

    assign beat.mode             = s_tuser;
    assign beat.slave_address    = s_tdata[6:0];
    assign beat.register_address = s_tdata[14:7];
    assign beat.pending          = s_tdata[15];
    assign beat.bus_state        = s_tdata[18:16];
    assign beat.received_byte    = s_tdata[26:19];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    i2crr_step u_step (
        .state_cur (state_reg),
        .beat      (beat),
        .state_nxt (state_next),
        .action    (action)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: load on accept only, hold while stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {2'b00,
                            (state_next.phase != PH_IDLE),
                            state_next.ready_flag,
                            state_next.data_word,
                            state_next.irq_enabled,
                            action.command,
                            action.write_byte,
                            action.write_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### sv/i2crr_checker.sv
// Port-level checks for the I2C register read sequencer, bound to the top level.
`default_nettype none
`include "i2c_register_read_sequencer_macros.svh"
module i2crr_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire [i2crr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire                             s_tuser,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [i2crr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2crr_pkg::*;

    logic unused_in;

    assign unused_in = s_tvalid ^ s_tready ^ s_tuser ^ (^s_tdata);

    `I2CRR_ASSERT_RST(a_no_beat_after_reset, !aresetn |=> !m_tvalid, "result beat right after reset")
    `I2CRR_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result beat changed")
    `I2CRR_ASSERT(a_write_cmd, m_tvalid && m_tdata[0] |-> (m_tdata[10:9] == CMD_START) || (m_tdata[10:9] == CMD_CONTINUE), "byte written without START or CONTINUE")
    `I2CRR_ASSERT(a_irq_busy, m_tvalid |-> m_tdata[11] == m_tdata[29], "interrupt enable differs from busy")
    `I2CRR_ASSERT(a_ready_idle, m_tvalid && m_tdata[28] |-> !m_tdata[29], "data ready while busy")

endmodule

bind i2c_register_read_sequencer i2crr_checker u_i2crr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
